// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each use expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

// The expression must never be true.
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

// File: sv/dmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

  // Field and register widths fixed by the interface.
  localparam int ADDR_W       = 32;
  localparam int CNT_W        = 32;
  localparam int LINES_LOG2_W = 4;
  localparam int MEM_LOG2_W   = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 5;

  // Reset values of the configuration registers.
  localparam logic [LINES_LOG2_W-1:0] LINES_LOG2_RST = 4'd10;
  localparam logic [MEM_LOG2_W-1:0]   MEM_LOG2_RST   = 5'd16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CACHE_LINES_LOG2 = 1'b0,
    REG_MEM_SIZE_LOG2    = 1'b1
  } dmc_reg_t;

  // Sequencer states: the tag memory is swept clean after reset, then runs.
  typedef enum logic [0:0] {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } dmc_state_t;

  // Outcome of one lookup, handed to the result stage.
  typedef struct packed {
    logic hit;
    logic oor;
  } dmc_flags_t;

endpackage

`default_nettype wire

// File: sv/dmc_tag_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dmc_tag_ram #(
  parameter int DEPTH  = 1024,
  parameter int IDX_W  = 10,
  parameter int DATA_W = 33
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IDX_W-1:0]  waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [IDX_W-1:0]  raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/dmc_result.sv
`timescale 1ns / 1ps
`default_nettype none

module dmc_result
  import dmc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             done,
  input  wire dmc_flags_t       flags,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic                  hit,
  output logic                  beyond_mem,
  output logic      [CNT_W-1:0] hit_count,
  output logic      [CNT_W-1:0] miss_count
);

  `include "assert_macros.svh"

  logic [CNT_W-1:0] hits_total;
  logic [CNT_W-1:0] misses_total;
  logic [CNT_W-1:0] hits_total_next;
  logic [CNT_W-1:0] misses_total_next;

  // Counter updates; an out-of-range access counts as neither.
  always_comb begin
    hits_total_next   = hits_total;
    misses_total_next = misses_total;
    if (flags.hit) begin
      hits_total_next = hits_total + CNT_W'(1);
    end else if (!flags.oor) begin
      misses_total_next = misses_total + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_total   <= '0;
      misses_total <= '0;
    end else if (done) begin
      hits_total   <= hits_total_next;
      misses_total <= misses_total_next;
    end
  end

  // Output register: filled by a finished lookup, emptied by a transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      hit        <= flags.hit;
      beyond_mem <= flags.oor;
      hit_count  <= hits_total_next;
      miss_count <= misses_total_next;
    end
  end

  `ASSERT_NEXT(a_done_fills_output, done, out_valid)
  `ASSERT_NEVER(a_hit_in_range, done && flags.hit && flags.oor)
  `ASSERT_NEXT(a_one_count_step, done && !flags.oor,
               CNT_W'(hits_total + misses_total) ==
               CNT_W'($past(hits_total) + $past(misses_total) + CNT_W'(1)))

endmodule

`default_nettype wire

// File: sv/direct_mapped_cache_lookup.sv
// Lookup path: an accepted address is held in the lookup stage while the tag memory is read;
// its result is registered in the output register once that register is empty or being read.
// Throughput: one address per cycle while results drain; a line fill is forwarded to a
// lookup of the same line that is accepted at the edge where the fill is written.
// Reset (synchronous, active high) clears counters and starts a sweep of the tag memory
// (2^floor(log2(MAX_LINES)) lines, 1024 by default), during which no address is accepted.
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_cache_lookup
  import dmc_pkg::*;
#(
  parameter int MAX_LINES = 1024,
  parameter int ADDR_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ADDR_W-1:0]     address,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       hit,
  output logic                       beyond_mem,
  output logic      [CNT_W-1:0]      hit_count,
  output logic      [CNT_W-1:0]      miss_count
);

  `include "assert_macros.svh"

  localparam int DEPTH_LOG2 = $clog2(MAX_LINES + 1) - 1;
  localparam int IDX_W      = (DEPTH_LOG2 > 0) ? DEPTH_LOG2 : 1;
  localparam int DEPTH      = 1 << DEPTH_LOG2;
  localparam int TAG_W      = ADDR_BITS;
  localparam int LINE_W     = TAG_W + 1;
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic [LINES_LOG2_W-1:0] cache_lines_log2;
  logic [MEM_LOG2_W-1:0]   mem_size_log2;

  dmc_state_t state;
  dmc_state_t state_next;
  logic       clearing;
  logic [IDX_W-1:0] clr_cnt;

  logic [ADDR_W-1:0]       addr_used;
  logic [LINES_LOG2_W-1:0] lg_eff;
  logic [ADDR_W-1:0]       idx_full;
  logic [ADDR_W-1:0]       tag_full;
  logic [IDX_W-1:0]        idx_in;
  logic [TAG_W-1:0]        tag_in;
  logic                    oor_in;
  logic                    accept;

  logic             stg_valid;
  logic [IDX_W-1:0] stg_idx;
  logic [TAG_W-1:0] stg_tag;
  logic             stg_oor;
  logic             byp_valid;
  logic [TAG_W-1:0] byp_tag;

  logic [LINE_W-1:0] rd_line;
  logic              line_ok;
  logic [TAG_W-1:0]  line_tag;
  logic              done;
  logic              lk_we;
  dmc_flags_t        flags;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINE_W-1:0] ram_wdata;
  logic [LINE_W-1:0] ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_lines_log2 <= LINES_LOG2_RST;
      mem_size_log2    <= MEM_LOG2_RST;
    end else if (cfg_we) begin
      unique case (dmc_reg_t'(cfg_index))
        REG_CACHE_LINES_LOG2: cache_lines_log2 <= cfg_data[LINES_LOG2_W-1:0];
        REG_MEM_SIZE_LOG2:    mem_size_log2    <= cfg_data[MEM_LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // Clear sequencer: state register and sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == IDX_W'(DEPTH - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    unique case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  // Address decode: range check, line index and tag by mask and shift.
  always_comb begin
    addr_used = address & ADDR_MASK;
    if (32'(cache_lines_log2) > DEPTH_LOG2) begin
      lg_eff = LINES_LOG2_W'(DEPTH_LOG2);
    end else begin
      lg_eff = cache_lines_log2;
    end
    idx_full = addr_used & ((ADDR_W'(1) << lg_eff) - ADDR_W'(1));
    tag_full = addr_used >> lg_eff;
    idx_in   = idx_full[IDX_W-1:0];
    tag_in   = tag_full[TAG_W-1:0];
    if (32'(mem_size_log2) >= ADDR_BITS) begin
      oor_in = 1'b0;
    end else begin
      oor_in = (addr_used >> mem_size_log2) != '0;
    end
  end

  // Lookup stage: the tag memory is read at accept and compared in the cycle after.
  assign rd_line  = byp_valid ? {1'b1, byp_tag} : ram_rdata;
  assign line_ok  = rd_line[LINE_W-1];
  assign line_tag = rd_line[TAG_W-1:0];
  assign done     = stg_valid && (!out_valid || out_ready);
  assign flags.hit = !stg_oor && line_ok && (line_tag == stg_tag);
  assign flags.oor = stg_oor;
  assign lk_we    = done && !flags.hit && !stg_oor;
  assign in_ready = !clearing && (!stg_valid || done);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (done) begin
      stg_valid <= 1'b0;
    end
  end

  // A fill written at the same edge as the next read is forwarded to it.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid <= 1'b0;
    end else if (accept) begin
      byp_valid <= lk_we && (stg_idx == idx_in);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_tag <= stg_tag;
      stg_idx <= idx_in;
      stg_tag <= tag_in;
      stg_oor <= oor_in;
    end
  end

  // Write port: the clearing sweep after reset, otherwise line fills.
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = lk_we;
      ram_waddr = stg_idx;
      ram_wdata = {1'b1, stg_tag};
    end
  end

  dmc_tag_ram #(
    .DEPTH  (DEPTH),
    .IDX_W  (IDX_W),
    .DATA_W (LINE_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (idx_in),
    .rdata (ram_rdata)
  );

  dmc_result u_result (
    .clk        (clk),
    .rst        (rst),
    .done       (done),
    .flags      (flags),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .hit        (hit),
    .beyond_mem (beyond_mem),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

  `ASSERT_IMPLIES(a_clear_blocks_input, clearing, !in_ready)
  `ASSERT_NEXT(a_accept_loads_stage, accept, stg_valid)
  `ASSERT_NEVER(a_oor_never_fills, stg_valid && stg_oor && lk_we)

endmodule

`default_nettype wire
